>>> hw/rtl/rmsd_pkg.sv
// shared constants and types for the windowed rms decimator
package rmsd_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WINDOW_BITS_DEF = 16;
    localparam int CFG_BITS        = 16;
    localparam int OUT_BITS        = 16;
    localparam int ACC_MAX_BITS    = 64;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

    typedef struct packed {
        logic              not_empty;
        logic [QCNT_W-1:0] count;
    } qstat_t;

endpackage

>>> hw/rtl/block_rms_decimator_top.sv
// top level of the windowed rms decimator
//
//  channel        handshake                      payload
//  input          in_valid / in_stall            sample, run_start
//  output         out_valid / out_stall          rms_value
//  config         window_length_we               window_length
//
//  one sample per cycle into the square-accumulate front while in_stall is low, two pipeline stages
//  the back end takes one finished window at a time through its bit-serial divider
//  and square root
//  the queue holds four finished windows; in_stall rises when it could overflow
//  reset clears the accumulator, count and queue, and window_length returns to 1
//  out_stall holds the result register; the front keeps running until the queue fills
module block_rms_decimator_top
    import rmsd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          run_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [OUT_BITS-1:0]           rms_value,
    input  logic                          window_length_we,
    input  logic [CFG_BITS-1:0]           window_length
);

    localparam int ACC_FULL = WINDOW_BITS + 2 * SAMPLE_BITS - 2;
    localparam int ACC_W    = (ACC_FULL > ACC_MAX_BITS) ? ACC_MAX_BITS : ACC_FULL;
    localparam int ENTRY_W  = ACC_W + WINDOW_BITS;

    qstat_t                 q_stat;
    logic                   push;
    logic [ACC_W-1:0]       push_sum;
    logic [WINDOW_BITS-1:0] push_win;
    logic                   pop;
    logic [ENTRY_W-1:0]     pop_data;

    rmsd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_BITS (WINDOW_BITS),
        .ACC_W       (ACC_W)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .run_start        (run_start),
        .window_length_we (window_length_we),
        .window_length    (window_length),
        .q_stat           (q_stat),
        .push             (push),
        .push_sum         (push_sum),
        .push_win         (push_win)
    );

    rmsd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_sum, push_win}),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    rmsd_back #(
        .WINDOW_BITS (WINDOW_BITS),
        .ACC_W       (ACC_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop       (pop),
        .pop_sum   (pop_data[ENTRY_W-1:WINDOW_BITS]),
        .pop_win   (pop_data[WINDOW_BITS-1:0]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rms_value (rms_value)
    );

endmodule

>>> hw/rtl/rmsd_front.sv
// front end: squares samples, accumulates windows, hands finished windows to the queue
module rmsd_front
    import rmsd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS = WINDOW_BITS_DEF,
    parameter int ACC_W       = 46
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          run_start,
    input  logic                          window_length_we,
    input  logic [CFG_BITS-1:0]           window_length,
    input  qstat_t                        q_stat,
    output logic                          push,
    output logic [ACC_W-1:0]              push_sum,
    output logic [WINDOW_BITS-1:0]        push_win
);

    logic [CFG_BITS-1:0]      wlen_reg;
    logic                     vld_reg;
    logic                     start_reg;
    logic [2*SAMPLE_BITS-1:0] sq_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [WINDOW_BITS-1:0]   cnt_reg;

    logic [SAMPLE_BITS-1:0]   sample_u;
    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] sq_next;
    logic                     accept;
    logic [WINDOW_BITS-1:0]   win_raw;
    logic [WINDOW_BITS-1:0]   win_eff;
    logic [ACC_W-1:0]         acc_base;
    logic [WINDOW_BITS-1:0]   cnt_base;
    logic [ACC_W:0]           sum_ext;
    logic [ACC_W-1:0]         acc_next;
    logic [WINDOW_BITS-1:0]   cnt_next;
    logic                     done;

    assign in_stall = ({1'b0, q_stat.count} + {{QCNT_W{1'b0}}, vld_reg})
                      >= (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept   = in_valid & ~in_stall;

    // magnitude and square
    always_comb
    begin
        sample_u = unsigned'(sample);
        mag      = sample_u[SAMPLE_BITS-1] ? (~sample_u + 1'b1) : sample_u;
        sq_next  = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
    end

    // saturating accumulate and window count
    always_comb
    begin
        win_raw  = WINDOW_BITS'(wlen_reg);
        win_eff  = (win_raw == '0) ? WINDOW_BITS'(1) : win_raw;
        acc_base = start_reg ? '0 : acc_reg;
        cnt_base = start_reg ? '0 : cnt_reg;
        sum_ext  = {1'b0, acc_base} + (ACC_W + 1)'(sq_reg);
        acc_next = sum_ext[ACC_W] ? {ACC_W{1'b1}} : sum_ext[ACC_W-1:0];
        cnt_next = cnt_base + 1'b1;
        done     = vld_reg && (cnt_next >= win_eff);
    end

    assign push     = done;
    assign push_sum = acc_next;
    assign push_win = win_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= CFG_BITS'(1);
            vld_reg  <= 1'b0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (window_length_we)
            begin
                wlen_reg <= window_length;
            end
            vld_reg <= accept;
            if (vld_reg)
            begin
                acc_reg <= done ? '0 : acc_next;
                cnt_reg <= done ? '0 : cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg    <= sq_next;
            start_reg <= run_start;
        end
    end

    a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != {WINDOW_BITS{1'b1}})
        else $error("window count reached its maximum");

endmodule

>>> hw/rtl/rmsd_queue.sv
// short queue of finished window sums between front and back
module rmsd_queue
    import rmsd_pkg::*;
#(
    parameter int WIDTH = 62,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output qstat_t           q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    assign pop_data         = mem_reg[rd_ptr_reg];
    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.count     = QCNT_W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(DEPTH)))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

>>> hw/rtl/rmsd_back.sv
// back end: bit-serial divide by window length, then bit-pair square root
module rmsd_back
    import rmsd_pkg::*;
#(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF,
    parameter int ACC_W       = 46
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  qstat_t                 q_stat,
    output logic                   pop,
    input  logic [ACC_W-1:0]       pop_sum,
    input  logic [WINDOW_BITS-1:0] pop_win,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OUT_BITS-1:0]    rms_value
);

    localparam int SQ_W   = ACC_W + (ACC_W % 2);
    localparam int ROOT_W = SQ_W / 2;
    localparam int STEP_W = $clog2(ACC_W + 1);
    localparam int EXT_W  = (ROOT_W > OUT_BITS) ? ROOT_W : OUT_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [ACC_W-1:0]       quo_reg;
    logic [WINDOW_BITS-1:0] rem_reg;
    logic [WINDOW_BITS-1:0] div_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [SQ_W-1:0]        rad_reg;
    logic [ROOT_W+1:0]      sqrem_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [OUT_BITS-1:0]    rms_reg;
    logic                   out_valid_reg;

    logic [WINDOW_BITS:0]   rem_shift;
    logic [WINDOW_BITS:0]   rem_sub;
    logic                   div_fit;
    logic [WINDOW_BITS-1:0] rem_next;
    logic [ACC_W-1:0]       quo_next;
    logic [ROOT_W+1:0]      sq_shift;
    logic [ROOT_W+1:0]      trial;
    logic                   sq_fit;
    logic [ROOT_W+1:0]      sqrem_next;
    logic [ROOT_W-1:0]      root_next;
    logic [EXT_W-1:0]       root_ext;
    logic [OUT_BITS-1:0]    rms_next;

    assign pop = (state_reg == ST_IDLE) && q_stat.not_empty;

    // restoring division step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[ACC_W-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        div_fit   = rem_shift >= {1'b0, div_reg};
        rem_next  = div_fit ? rem_sub[WINDOW_BITS-1:0] : rem_shift[WINDOW_BITS-1:0];
        quo_next  = {quo_reg[ACC_W-2:0], div_fit};
    end

    // square root step, two radicand bits per cycle
    always_comb
    begin
        sq_shift   = {sqrem_reg[ROOT_W-1:0], rad_reg[SQ_W-1 -: 2]};
        trial      = {root_reg, 2'b01};
        sq_fit     = sq_shift >= trial;
        sqrem_next = sq_fit ? (sq_shift - trial) : sq_shift;
        root_next  = {root_reg[ROOT_W-2:0], sq_fit};
        root_ext   = EXT_W'(root_next);
        rms_next   = (root_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : root_ext[OUT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            quo_reg       <= '0;
            rem_reg       <= '0;
            div_reg       <= '0;
            step_reg      <= '0;
            rad_reg       <= '0;
            sqrem_reg     <= '0;
            root_reg      <= '0;
            rms_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_stat.not_empty)
                    begin
                        quo_reg   <= pop_sum;
                        div_reg   <= pop_win;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    if (step_reg == STEP_W'(ACC_W - 1))
                    begin
                        rad_reg   <= SQ_W'(quo_next);
                        sqrem_reg <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SQRT:
                begin
                    rad_reg   <= {rad_reg[SQ_W-3:0], 2'b00};
                    sqrem_reg <= sqrem_next;
                    root_reg  <= root_next;
                    if (step_reg == STEP_W'(ROOT_W - 1))
                    begin
                        rms_reg       <= rms_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign rms_value = rms_reg;

endmodule
